/* src/pkr_pkg.sv */
// shared types, constants and helpers for the aligned record packer
// no dependencies; compiled first

package pkr_pkg;

	// default limit on the number of fields per record
	localparam int MAX_FIELDS_DEF = 16;
	// slots in the field type register
	localparam int NUM_SLOTS = 16;
	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	// most result bytes one item can cause
	localparam int MAX_RESULTS = 6;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_RECORD_COUNT  = 2'd0,
		REG_FIELD_COUNT   = 2'd1,
		REG_FIELD_TYPES   = 2'd2,
		REG_LITTLE_ENDIAN = 2'd3
	} cfg_reg_t;

	// item commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// field type codes
	typedef logic [1:0] ftype_t;
	localparam ftype_t TYPE_NONE  = 2'd0;
	localparam ftype_t TYPE_BYTE  = 2'd1;
	localparam ftype_t TYPE_SHORT = 2'd2;
	localparam ftype_t TYPE_WORD  = 2'd3;

	// configuration as seen by the front
	typedef struct packed {
		logic [7:0]  record_count;
		logic [4:0]  num_fields;
		logic [31:0] field_types;
		logic        little_endian;
		logic [7:0]  record_size;
		logic        busy;
	} cfg_t;

	// one queued job: result bytes in output order and how many are valid
	typedef struct packed {
		logic [2:0]                  count;
		logic [MAX_RESULTS-1:0][7:0] bytes;
	} job_t;

	// head of the queue as seen by the back
	typedef struct packed {
		logic valid;
		job_t job;
	} qhead_t;

	// byte size of a field type
	function automatic logic [2:0] size_of(ftype_t t);
		logic [2:0] s;
		unique case (t)
			TYPE_BYTE:  s = 3'd1;
			TYPE_SHORT: s = 3'd2;
			TYPE_WORD:  s = 3'd4;
			default:    s = 3'd0;
		endcase
		return s;
	endfunction

	// type of field k, zero past the register
	function automatic ftype_t type_of(logic [31:0] types, logic [4:0] k);
		ftype_t t;
		if (k >= 5'(NUM_SLOTS)) begin
			t = TYPE_NONE;
		end else begin
			t = types[{k[3:0], 1'b0} +: 2];
		end
		return t;
	endfunction

	// first sized field at or after idx, else n; idx itself when idx >= n
	function automatic logic [4:0] skip_empty(logic [4:0] idx, logic [31:0] types,
			logic [4:0] n);
		logic [4:0] res;
		logic       found;
		res = (idx < n) ? n : idx;
		found = 1'b0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (!found && 5'(k) >= idx && 5'(k) < n
					&& types[2*k +: 2] != TYPE_NONE) begin
				res = 5'(k);
				found = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

/* src/pkr_if.sv */
// valid/ready channel interfaces for input items and result items
// no dependencies

interface pkr_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;

	modport source(output valid, command, data_byte, input ready);
	modport sink(input valid, command, data_byte, output ready);
endinterface

interface pkr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source(output valid, out_byte, last_of_run, input ready);
	modport sink(input valid, out_byte, last_of_run, output ready);
endinterface

/* src/aligned_record_packer_core.sv */
// a result byte passes through the job queue and then the output register before it is valid at the output
// throughput: one item per cycle unless the queue is full or cfg busy; a start item yields up to six result bytes
// writing field_count or field_types stalls items while record size is recomputed, one slot a cycle
// the four-entry job queue lets input continue while results wait at the output
// reset: asynchronous, active low; registers to defaults (little_endian 1), position cleared
// top level; depends on pkr_pkg, pkr_if, pkr_cfg, pkr_front, pkr_queue, pkr_back

module aligned_record_packer_core
	import pkr_pkg::*;
#(
	parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pkr_in_if.sink      in,
	pkr_out_if.source   out,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	cfg_t   cfg;
	logic   q_full;
	logic   push;
	job_t   push_job;
	logic   pop;
	qhead_t head;

	// configuration and record size
	pkr_cfg #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// item classification
	pkr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in       (in),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// job queue
	pkr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	// result serializer
	pkr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out    (out)
	);

endmodule

/* src/pkr_cfg.sv */
// configuration registers and the sequential record size calculator
// depends on pkr_pkg

module pkr_cfg
	import pkr_pkg::*;
#(
	parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  index,
	input  logic [31:0] wdata,
	output cfg_t        cfg
);

	localparam int LIMIT = (MAX_FIELDS < NUM_SLOTS) ? MAX_FIELDS : NUM_SLOTS;
	localparam int KW = $clog2(NUM_SLOTS);

	logic [7:0]    record_count_q;
	logic [4:0]    field_count_q;
	logic [31:0]   field_types_q;
	logic          little_endian_q;
	logic          busy_q;
	logic [KW-1:0] k_q;
	logic [7:0]    total_q;
	logic [2:0]    maxal_q;

	logic [4:0] n;
	logic       layout_wr;
	ftype_t     t;
	logic [2:0] s;
	logic [7:0] mask;
	logic [7:0] aligned;
	logic [7:0] amask;

	// field count limited to the supported number
	assign n = (field_count_q > 5'(LIMIT)) ? 5'(LIMIT) : field_count_q;
	assign layout_wr = wr_en && (cfg_reg_t'(index) == REG_FIELD_COUNT
		|| cfg_reg_t'(index) == REG_FIELD_TYPES);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_count_q  <= '0;
			field_count_q   <= '0;
			field_types_q   <= '0;
			little_endian_q <= 1'b1;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(index))
				REG_RECORD_COUNT:  record_count_q  <= wdata[7:0];
				REG_FIELD_COUNT:   field_count_q   <= wdata[4:0];
				REG_FIELD_TYPES:   field_types_q   <= wdata;
				REG_LITTLE_ENDIAN: little_endian_q <= wdata[0];
			endcase
		end
	end

	// one field per cycle: align the running offset and add the field size
	always_comb begin
		t = (5'(k_q) < n) ? field_types_q[{k_q, 1'b0} +: 2] : TYPE_NONE;
		s = size_of(t);
		mask = 8'(s) - 8'd1;
		aligned = (total_q + mask) & ~mask;
		amask = 8'(maxal_q) - 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			k_q     <= '0;
			total_q <= '0;
			maxal_q <= 3'd1;
		end else if (layout_wr) begin
			busy_q  <= 1'b1;
			k_q     <= '0;
			total_q <= '0;
			maxal_q <= 3'd1;
		end else if (busy_q) begin
			if (s != 3'd0) begin
				total_q <= aligned + 8'(s);
				if (s > maxal_q) begin
					maxal_q <= s;
				end
			end
			k_q <= k_q + 1'b1;
			if (k_q == KW'(NUM_SLOTS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// configuration outputs; record size padded to the largest alignment
	always_comb begin
		cfg.record_count  = record_count_q;
		cfg.num_fields    = n;
		cfg.field_types   = field_types_q;
		cfg.little_endian = little_endian_q;
		cfg.record_size   = (total_q + amask) & ~amask;
		cfg.busy          = busy_q;
	end

endmodule

/* src/pkr_front.sv */
// front: accepts items, tracks the record position and builds result jobs
// depends on pkr_pkg and pkr_in_if

module pkr_front
	import pkr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	pkr_in_if.sink   in,
	input  cfg_t     cfg,
	input  logic     q_full,
	output logic     push,
	output job_t     push_job
);

	logic [6:0] off_q;
	logic [4:0] fi_q;
	logic [1:0] pos_q;
	logic [7:0] swap_q [3];

	logic       accept;
	logic [4:0] n;
	logic [7:0] d;
	logic [4:0] fi0;
	logic [4:0] fi1;
	logic [4:0] fi2;
	logic [1:0] pos1;
	logic [6:0] off1;
	logic [2:0] s;
	logic [1:0] smask;
	logic       field_ok;
	logic       is_pad;
	logic       is_last;
	logic       swap_we;
	logic       rec_done;
	logic [5:0] ngrp;
	logic [1:0] sidx;
	job_t       job;

	assign in.ready = !cfg.busy && !q_full;
	assign accept = in.valid && in.ready;

	// classify the item and build its result bytes
	always_comb begin
		n = cfg.num_fields;
		d = in.data_byte;
		fi0 = skip_empty(fi_q, cfg.field_types, n);
		field_ok = fi0 < n;
		s = size_of(type_of(cfg.field_types, fi0));
		smask = s[1:0] - 2'd1;
		is_pad = (pos_q == 2'd0) && ((off_q[1:0] & smask) != 2'd0);
		is_last = ({1'b0, pos_q} + 3'd1) >= s;
		ngrp = ({1'b0, n} + 6'd3) >> 2;
		job.count = 3'd0;
		job.bytes = '0;
		fi1 = fi0;
		pos1 = pos_q;
		swap_we = 1'b0;
		sidx = '0;
		if (in.command == CMD_START) begin
			// header: count, field count with byte order flag, packed types
			job.bytes[0] = cfg.record_count;
			job.bytes[1] = {cfg.little_endian, 2'b00, n};
			for (int g = 0; g < 4; g++) begin
				for (int m = 0; m < 4; m++) begin
					if (5'(4*g + m) < n) begin
						job.bytes[2+g][7-2*m -: 2] = cfg.field_types[2*(4*g+m) +: 2];
					end
				end
			end
			job.count = 3'd2 + ngrp[2:0];
		end else if (field_ok && !is_pad) begin
			if (is_last) begin
				// field completes: this byte, then held bytes reversed if big endian
				job.bytes[0] = d;
				job.count = 3'd1;
				if (!cfg.little_endian) begin
					for (int i = 1; i < 4; i++) begin
						if (pos_q >= 2'(i)) begin
							sidx = pos_q - 2'(i);
							job.bytes[i] = swap_q[sidx];
						end
					end
					job.count = 3'd1 + 3'(pos_q);
				end
				fi1 = fi0 + 5'd1;
				pos1 = 2'd0;
			end else begin
				// field continues: hold the byte; little endian passes it on in memory order
				swap_we = 1'b1;
				job.bytes[0] = d;
				job.count = cfg.little_endian ? 3'd1 : 3'd0;
				pos1 = pos_q + 2'd1;
			end
		end
		off1 = off_q + 7'd1;
		fi2 = skip_empty(fi1, cfg.field_types, n);
		rec_done = (fi2 >= n) && ({1'b0, off1} >= cfg.record_size);
	end

	assign push = accept && (job.count != 3'd0);
	assign push_job = job;

	// record position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			fi_q  <= '0;
			pos_q <= '0;
		end else if (accept) begin
			if (in.command == CMD_START || rec_done) begin
				off_q <= '0;
				fi_q  <= '0;
				pos_q <= '0;
			end else begin
				off_q <= off1;
				fi_q  <= fi2;
				pos_q <= pos1;
			end
		end
	end

	// earlier bytes of the current field
	always_ff @(posedge clk) begin
		if (accept && in.command == CMD_DATA && swap_we && pos_q != 2'd3) begin
			swap_q[pos_q] <= d;
		end
	end

`ifndef SYNTHESIS
	a_fi_range: assert property (@(posedge clk) disable iff (!arst_n)
		fi_q <= 5'(NUM_SLOTS))
		else $error("field index past the last slot");
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in.command == CMD_START |=> off_q == '0 && fi_q == '0 && pos_q == '0)
		else $error("start item did not restart the record position");
`endif

endmodule

/* src/pkr_queue.sv */
// short job queue between front and back
// depends on pkr_pkg

module pkr_queue
	import pkr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   push_job,
	output logic   full,
	input  logic   pop,
	output qhead_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full = cnt_q == CW'(QUEUE_DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.job = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// job storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("job pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("job popped from an empty queue");
`endif

endmodule

/* src/pkr_back.sv */
// back: sends the bytes of each queued job, one per cycle while the output is ready, through an output register
// depends on pkr_pkg and pkr_out_if

module pkr_back
	import pkr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  qhead_t   head,
	output logic     pop,
	pkr_out_if.source out
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic load;
	logic last;

	assign load = head.valid && (!valid_q || out.ready);
	assign last = idx_q == (head.job.count - 3'd1);
	assign pop = load && last;

	assign out.valid = valid_q;
	assign out.out_byte = byte_q;
	assign out.last_of_run = last_q;

	// byte index within the head job and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (out.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.job.bytes[idx_q];
			last_q <= last;
		end
	end

`ifndef SYNTHESIS
	a_job_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> head.job.count != 3'd0)
		else $error("queued job carries no bytes");
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> idx_q < head.job.count)
		else $error("byte index past the end of the head job");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for aligned_record_packer_core: predicts the packed byte stream
// depends on pkr_pkg, pkr_if and the core with its submodules

module testbench;
	import pkr_pkg::*;

	localparam int FIELD_LIMIT = MAX_FIELDS_DEF;
	localparam int unsigned TOTAL_ITEMS = 250;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} send_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} packed_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	pkr_in_if  in_ch();
	pkr_out_if out_ch();

	aligned_record_packer_core #(.MAX_FIELDS(FIELD_LIMIT)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in_ch),
		.out       (out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor copy of the registers and the record position
	logic [7:0]  cfg_rec_count = 8'd0;
	logic [4:0]  cfg_num_fields = 5'd0;
	logic [31:0] cfg_types = 32'd0;
	logic        cfg_le = 1'b1;
	logic [6:0]  pos_offset = 7'd0;
	logic [4:0]  pos_field = 5'd0;
	logic [1:0]  pos_byte = 2'd0;
	logic [7:0]  held_bytes [3];

	send_item_t   items_to_send [$];
	packed_byte_t packed_bytes_due [$];
	int unsigned  items_queued = 0;
	int unsigned  errors = 0;
	int unsigned  tx_idle_pct = 25;
	int unsigned  rx_idle_pct = 56;
	int unsigned  hold_left = 0;
	logic         in_taken;

	always #6 clk = ~clk;

	// fields in use after the count limits
	function automatic int unsigned active_fields();
		int unsigned n;
		n = cfg_num_fields;
		if (n > FIELD_LIMIT) n = FIELD_LIMIT;
		if (n > NUM_SLOTS) n = NUM_SLOTS;
		return n;
	endfunction

	function automatic ftype_t field_type(int unsigned k);
		if (k >= NUM_SLOTS) return TYPE_NONE;
		return cfg_types[2*k +: 2];
	endfunction

	function automatic int unsigned field_bytes(ftype_t t);
		case (t)
			TYPE_BYTE:  return 1;
			TYPE_SHORT: return 2;
			TYPE_WORD:  return 4;
			default:    return 0;
		endcase
	endfunction

	// record size with natural alignment and tail padding
	function automatic int unsigned padded_size(int unsigned n);
		int unsigned total, align, s;
		total = 0;
		align = 1;
		for (int unsigned k = 0; k < n; k++) begin
			s = field_bytes(field_type(k));
			if (s != 0) begin
				total = ((total + s - 1) & ~(s - 1)) + s;
				if (s > align) align = s;
			end
		end
		return (total + align - 1) & ~(align - 1);
	endfunction

	function automatic void skip_unsized(int unsigned n);
		while (pos_field < n && field_type(pos_field) == TYPE_NONE) pos_field++;
	endfunction

	// packed bytes caused by one accepted item
	function automatic void pack_item(logic cmd, logic [7:0] d);
		int unsigned  n, s;
		logic         aligned;
		logic [7:0]   hdr;
		logic [7:0]   res [$];
		packed_byte_t e;
		n = active_fields();
		if (cmd == CMD_START) begin
			res.push_back(cfg_rec_count);
			res.push_back({cfg_le, 7'(n)});
			for (int unsigned g = 0; g * 4 < n; g++) begin
				hdr = 8'd0;
				for (int unsigned m = 0; m < 4; m++) begin
					if (g * 4 + m < n) hdr |= 8'(field_type(g * 4 + m)) << (6 - 2 * m);
				end
				res.push_back(hdr);
			end
			pos_offset = '0;
			pos_field = '0;
			pos_byte = '0;
		end else begin
			skip_unsized(n);
			if (pos_field < n) begin
				s = field_bytes(field_type(pos_field));
				aligned = (pos_byte != 0) || ((pos_offset & (s - 1)) == 0);
				// field complete: big endian replays the held bytes in reverse
				if (aligned && pos_byte + 1 >= s) begin
					res.push_back(d);
					if (!cfg_le) begin
						for (int p = pos_byte; p > 0; p--) res.push_back(held_bytes[p - 1]);
					end
					pos_field = 5'(pos_field + 1);
					pos_byte = '0;
				end else if (aligned) begin
					held_bytes[pos_byte] = d;
					if (cfg_le) res.push_back(d);
					pos_byte = 2'(pos_byte + 1);
				end
			end
			pos_offset = 7'(pos_offset + 1);
			skip_unsized(n);
			if (pos_field >= n && pos_offset >= padded_size(n)) begin
				pos_offset = '0;
				pos_field = '0;
				pos_byte = '0;
			end
		end
		foreach (res[i]) begin
			e.out_byte = res[i];
			e.last_of_run = (i == res.size() - 1);
			packed_bytes_due.push_back(e);
		end
	endfunction

	function automatic void push_item(logic cmd, logic [7:0] d);
		items_to_send.push_back('{command: cmd, data_byte: d});
		items_queued++;
	endfunction

	function automatic void push_bytes(int unsigned count);
		repeat (count) push_item(CMD_DATA, 8'($urandom));
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_RECORD_COUNT:  cfg_rec_count = value[7:0];
			REG_FIELD_COUNT:   cfg_num_fields = value[4:0];
			REG_FIELD_TYPES:   cfg_types = value;
			REG_LITTLE_ENDIAN: cfg_le = value[0];
			default: ;
		endcase
	endtask

	// write the registers selected in which, then release the port
	task automatic configure(logic [7:0] rc, logic [4:0] fc, logic [31:0] types, logic le,
			logic [3:0] which);
		if (which[REG_RECORD_COUNT]) write_reg(REG_RECORD_COUNT, 32'(rc));
		if (which[REG_FIELD_COUNT]) write_reg(REG_FIELD_COUNT, 32'(fc));
		if (which[REG_FIELD_TYPES]) write_reg(REG_FIELD_TYPES, types);
		if (which[REG_LITTLE_ENDIAN]) write_reg(REG_LITTLE_ENDIAN, 32'(le));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// all items sent, all bytes seen, then room for items that cause none
	task automatic wait_drained();
		do @(posedge clk);
		while (items_to_send.size() != 0 || in_ch.valid || packed_bytes_due.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	// item driver
	always @(negedge clk) begin : drive_items
		send_item_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_taken) begin
			if (items_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = items_to_send.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.command <= nxt.command;
				in_ch.data_byte <= nxt.data_byte;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver, with a counted hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: predict on accepted items, check accepted results
	always @(posedge clk) begin : check_results
		packed_byte_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready) pack_item(in_ch.command, in_ch.data_byte);
			if (out_ch.valid && out_ch.ready) begin
				if (packed_bytes_due.size() == 0) begin
					$error("unexpected result: out_byte %02h last_of_run %b",
						out_ch.out_byte, out_ch.last_of_run);
					errors++;
				end else begin
					want = packed_bytes_due.pop_front();
					if (out_ch.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h", want.out_byte,
							out_ch.out_byte);
						errors++;
					end
					if (out_ch.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %b, got %b", want.last_of_run,
							out_ch.last_of_run);
						errors++;
					end
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic [7:0]  rc;
		logic [4:0]  fc;
		logic [31:0] types;
		logic        le;
		logic [3:0]  which;
		int unsigned size, nrec;
		logic        held_off;
		held_off = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_DATA;
		in_ch.data_byte = 8'd0;
		out_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_RECORD_COUNT;
		cfg_wdata = 32'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (20) @(posedge clk);

		// reset defaults: no sized fields, data bytes dropped
		push_item(CMD_START, 8'hFF);
		push_item(CMD_DATA, 8'h00);
		push_item(CMD_DATA, 8'hFF);
		wait_drained();

		// largest header, all words
		configure(8'd255, 5'd16, 32'hFFFF_FFFF, 1'b1, 4'hF);
		push_item(CMD_START, 8'h00);
		push_item(CMD_DATA, 8'h00);
		push_item(CMD_DATA, 8'hFF);
		push_item(CMD_DATA, 8'hA5);
		push_item(CMD_DATA, 8'h5A);
		wait_drained();

		// field count over the limit, empty slots; stop inside a short field
		configure(8'h5A, 5'd31, 32'h0000_0039, 1'b1, 4'hF);
		push_item(CMD_START, 8'h3C);
		push_item(CMD_DATA, 8'h11);
		push_item(CMD_DATA, 8'hEE);
		push_item(CMD_DATA, 8'h22);
		wait_drained();

		// switch to big endian mid field, then finish the record
		configure(cfg_rec_count, cfg_num_fields, cfg_types, 1'b0,
			4'(1 << REG_LITTLE_ENDIAN));
		push_item(CMD_DATA, 8'h33);
		push_item(CMD_DATA, 8'h44);
		push_item(CMD_DATA, 8'h55);
		push_item(CMD_DATA, 8'h66);
		push_item(CMD_DATA, 8'h77);
		push_item(CMD_DATA, 8'h88);
		push_item(CMD_DATA, 8'h99);
		push_item(CMD_DATA, 8'hAA);
		wait_drained();

		// short shrinks to a byte with one byte already held
		configure(cfg_rec_count, cfg_num_fields, 32'h0000_0035, cfg_le,
			4'(1 << REG_FIELD_TYPES));
		push_item(CMD_DATA, 8'hBB);

		// random phases
		while (items_queued < TOTAL_ITEMS) begin
			wait_drained();
			if (items_queued < 100) begin
				tx_idle_pct = 25;
				rx_idle_pct = 56;
			end else if (items_queued < 200) begin
				tx_idle_pct = 56;
				rx_idle_pct = 25;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			case ($urandom_range(3))
				0: rc = 8'd0;
				1: rc = 8'd255;
				default: rc = 8'($urandom);
			endcase
			case ($urandom_range(9))
				0: fc = 5'd0;
				1: fc = 5'd16;
				2: fc = 5'($urandom_range(17, 31));
				3: fc = 5'($urandom_range(7, 15));
				default: fc = 5'($urandom_range(1, 6));
			endcase
			case ($urandom_range(7))
				0: types = 32'hFFFF_FFFF;
				1: types = 32'h5555_5555;
				2: types = 32'hAAAA_AAAA;
				3: types = 32'h0;
				default: types = $urandom;
			endcase
			le = 1'($urandom_range(1));
			which = ($urandom_range(3) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;

			// fill the block while the receiver holds off
			if (!held_off && items_queued >= 130) begin
				configure(rc, 5'd4, 32'h5555_5555, le, 4'hF);
				push_item(CMD_START, 8'($urandom));
				push_bytes(40);
				@(posedge clk);
				hold_left = 150;
				held_off = 1'b1;
				continue;
			end

			configure(rc, fc, types, le, which);
			size = padded_size(active_fields());
			if ($urandom_range(9) < 8) begin
				// well-formed records, sometimes without a new header or with a partial record after
				if ($urandom_range(4) != 0) push_item(CMD_START, 8'($urandom));
				if (size == 0) begin
					push_bytes($urandom_range(2, 6));
				end else begin
					nrec = $urandom_range(1, (size >= 36) ? 1 : 36 / size);
					push_bytes(nrec * size);
					if ($urandom_range(2) == 0)
						push_bytes($urandom_range(1, (size > 1) ? size - 1 : 1));
				end
			end else begin
				// noise with stray headers
				repeat ($urandom_range(5, 20))
					push_item(($urandom_range(7) == 0) ? CMD_START : CMD_DATA, 8'($urandom));
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
